/* sv/signal_subscription_table_core_macros.svh */
// ----------------------------------------------------------------------------
// signal subscription table assertion macros
// clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SIGNAL_SUBSCRIPTION_TABLE_CORE_MACROS_SVH
`define SIGNAL_SUBSCRIPTION_TABLE_CORE_MACROS_SVH

// consequent checked in the same cycle
`define SST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg
// request and status codes and the event record between sequencer and top
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

	// request codes
	localparam logic [1:0] REQ_CONNECT    = 2'd0;
	localparam logic [1:0] REQ_DISCONNECT = 2'd1;
	localparam logic [1:0] REQ_EMIT       = 2'd2;
	localparam logic [1:0] REQ_UNUSED     = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// fixed field widths of the result ports
	localparam int CALL_TASK_W  = 8;
	localparam int FREE_COUNT_W = 8;

	// one event from the scan sequencer
	typedef struct packed {
		logic       strobe;
		logic       dispatch;
		logic [1:0] status;
		logic       last;
		logic       free_dec;
		logic       free_inc;
	} sst_evt_t;

endpackage

`default_nettype wire

/* sv/signal_subscription_table_core.sv */
// ----------------------------------------------------------------------------
// signal_subscription_table_core
// subscription table of signal and task pairs with connect, disconnect and
// emit requests
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block walks its
// slot memory one slot per cycle through a single read port; a disconnect
// or emit walks every slot, a connect stops after the lowest free slot
// (or walks every slot when the table is full), and a connect or emit with
// signal 0 or an unused request code skips the walk and goes straight to
// its closing result. Each result is on the ports for exactly one cycle,
// marked by strobe; there is no way to hold results off, so the receiver
// must take every strobe. An emit gives one dispatch result per matching
// slot with a nonzero task, in slot order, then a closing result with last
// high; every other request gives the closing result alone. free_slots is
// the free slot count after the request. Unwritten slots read as free
// through per-slot valid bits cleared by reset, so the block is ready right
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module signal_subscription_table_core import sst_pkg::*; #(
	parameter int SLOTS       = 16,
	parameter int SIGNAL_BITS = 16,
	parameter int TASK_BITS   = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request side
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] signal_id,
	input  wire logic [7:0]  task_id,
	input  wire logic [15:0] arg_count,
	input  wire logic [31:0] arg_word,
	// result side
	output logic             strobe,
	output logic             dispatch,
	output logic [7:0]       call_task,
	output logic [15:0]      call_count,
	output logic [31:0]      call_word,
	output logic [1:0]       status,
	output logic [7:0]       free_slots,
	output logic             last
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// request fields cut to the configured widths
	logic [SIGNAL_BITS-1:0] req_sig;
	logic [TASK_BITS-1:0]   req_task;

	// memory ports
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [SIGNAL_BITS-1:0] rd_sig;
	logic [TASK_BITS-1:0]   rd_task;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [SIGNAL_BITS-1:0] wr_sig;
	logic [TASK_BITS-1:0]   wr_task;

	// sequencer events
	sst_evt_t               evt;
	logic [TASK_BITS-1:0]   evt_task;

	// arguments of the request in progress
	logic [15:0]            cnt_q;
	logic [31:0]            word_q;

	// free slot count kept alongside the memory
	logic [CW-1:0]          free_q;

	assign req_sig  = SIGNAL_BITS'(signal_id);
	assign req_task = TASK_BITS'(task_id);

	sst_slot_mem #(
		.SLOTS       (SLOTS),
		.SIGNAL_BITS (SIGNAL_BITS),
		.TASK_BITS   (TASK_BITS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_sig  (rd_sig),
		.rd_task (rd_task),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_sig  (wr_sig),
		.wr_task (wr_task)
	);

	sst_seq #(
		.SLOTS       (SLOTS),
		.SIGNAL_BITS (SIGNAL_BITS),
		.TASK_BITS   (TASK_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.req_sig  (req_sig),
		.req_task (req_task),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_sig   (rd_sig),
		.rd_task  (rd_task),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_sig   (wr_sig),
		.wr_task  (wr_task),
		.evt      (evt),
		.evt_task (evt_task)
	);

	// capture emit arguments with the request
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cnt_q  <= arg_count;
			word_q <= arg_word;
		end
	end

	// free count: a connect takes a slot, a disconnect of a live slot frees one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= CW'(SLOTS);
		end else if (evt.free_dec) begin
			free_q <= free_q - CW'(1);
		end else if (evt.free_inc) begin
			free_q <= free_q + CW'(1);
		end
	end

	// result strobe, one cycle per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= evt.strobe;
		end
	end

	// result payload; closing results carry zero task and arguments
	always_ff @(posedge clk) begin
		if (evt.strobe) begin
			dispatch   <= evt.dispatch;
			call_task  <= evt.dispatch ? CALL_TASK_W'(evt_task) : '0;
			call_count <= evt.dispatch ? cnt_q : '0;
			call_word  <= evt.dispatch ? word_q : '0;
			status     <= evt.status;
			free_slots <= FREE_COUNT_W'(free_q);
			last       <= evt.last;
		end
	end

endmodule

`default_nettype wire

/* sv/sst_slot_mem.sv */
// ----------------------------------------------------------------------------
// sst_slot_mem
// slot memory: signal and task per slot, one read and one write port,
// registered read, valid bits make unwritten slots read as free
// ----------------------------------------------------------------------------
`default_nettype none

module sst_slot_mem #(
	parameter int SLOTS       = 16,
	parameter int SIGNAL_BITS = 16,
	parameter int TASK_BITS   = 8,
	localparam int AW         = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   rd_en,
	input  wire logic [AW-1:0]          rd_addr,
	output logic      [SIGNAL_BITS-1:0] rd_sig,
	output logic      [TASK_BITS-1:0]   rd_task,
	input  wire logic                   wr_en,
	input  wire logic [AW-1:0]          wr_addr,
	input  wire logic [SIGNAL_BITS-1:0] wr_sig,
	input  wire logic [TASK_BITS-1:0]   wr_task
);

	logic [SIGNAL_BITS-1:0] sig_mem [SLOTS];
	logic [TASK_BITS-1:0]   task_mem [SLOTS];
	logic [SLOTS-1:0]       valid_q;
	logic [SIGNAL_BITS-1:0] sig_s1;
	logic [TASK_BITS-1:0]   task_s1;
	logic                   valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sig_mem[wr_addr]  <= wr_sig;
			task_mem[wr_addr] <= wr_task;
		end
		if (rd_en) begin
			sig_s1  <= sig_mem[rd_addr];
			task_s1 <= task_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	// never written slot reads as free with no task
	assign rd_sig  = valid_s1 ? sig_s1 : '0;
	assign rd_task = valid_s1 ? task_s1 : '0;

endmodule

`default_nettype wire

/* sv/sst_seq.sv */
// ----------------------------------------------------------------------------
// sst_seq
// request sequencer: walks the slot memory one slot a cycle, compares,
// writes back and raises result and free count events
// ----------------------------------------------------------------------------
`default_nettype none

module sst_seq import sst_pkg::*; #(
	parameter int SLOTS       = 16,
	parameter int SIGNAL_BITS = 16,
	parameter int TASK_BITS   = 8,
	localparam int AW         = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CW         = $clog2(SLOTS + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [1:0]             req_type,
	input  wire logic [SIGNAL_BITS-1:0] req_sig,
	input  wire logic [TASK_BITS-1:0]   req_task,
	output logic                        rd_en,
	output logic      [AW-1:0]          rd_addr,
	input  wire logic [SIGNAL_BITS-1:0] rd_sig,
	input  wire logic [TASK_BITS-1:0]   rd_task,
	output logic                        wr_en,
	output logic      [AW-1:0]          wr_addr,
	output logic      [SIGNAL_BITS-1:0] wr_sig,
	output logic      [TASK_BITS-1:0]   wr_task,
	output sst_evt_t                    evt,
	output logic      [TASK_BITS-1:0]   evt_task
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FINAL = 2'd2;

	logic [1:0]             state_q;
	logic [1:0]             req_q;
	logic [SIGNAL_BITS-1:0] sig_q;
	logic [TASK_BITS-1:0]   task_q;
	logic [1:0]             st_q;
	logic [CW-1:0]          rd_idx_q;
	logic                   v_s1;
	logic [AW-1:0]          addr_s1;
	logic                   sig_hit;
	logic                   found;
	logic                   scan_end;

	assign busy     = (state_q != S_IDLE);
	assign rd_en    = (state_q == S_SCAN) && (rd_idx_q < CW'(SLOTS));
	assign rd_addr  = rd_idx_q[AW-1:0];
	assign sig_hit  = (rd_sig == sig_q);
	assign found    = v_s1 && (req_q == REQ_CONNECT) && (rd_sig == '0);
	assign scan_end = v_s1 && (addr_s1 == AW'(SLOTS - 1));
	assign wr_addr  = addr_s1;
	assign evt_task = rd_task;

	always_comb begin
		wr_en   = 1'b0;
		wr_sig  = sig_q;
		wr_task = task_q;
		evt     = '0;
		if (state_q == S_FINAL) begin
			evt.strobe = 1'b1;
			evt.status = st_q;
			evt.last   = 1'b1;
		end else if (v_s1) begin
			case (req_q)
				REQ_CONNECT: begin
					if (rd_sig == '0) begin
						wr_en        = 1'b1;
						evt.free_dec = 1'b1;
					end
				end
				REQ_DISCONNECT: begin
					// task kept, only the signal is cleared
					if (sig_hit && (rd_task == task_q)) begin
						wr_en        = 1'b1;
						wr_sig       = '0;
						wr_task      = rd_task;
						evt.free_inc = (sig_q != '0);
					end
				end
				REQ_EMIT: begin
					if (sig_hit && (rd_task != '0)) begin
						evt.strobe   = 1'b1;
						evt.dispatch = 1'b1;
						evt.status   = ST_OK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= rd_addr;
		end
		if (start && !busy) begin
			req_q  <= req_type;
			sig_q  <= req_sig;
			task_q <= req_task;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			st_q     <= ST_OK;
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					v_s1     <= 1'b0;
					rd_idx_q <= '0;
					if (start) begin
						if ((req_type == REQ_CONNECT || req_type == REQ_EMIT)
							&& req_sig == '0) begin
							st_q    <= ST_ZERO;
							state_q <= S_FINAL;
						end else if (req_type == REQ_UNUSED) begin
							st_q    <= ST_OK;
							state_q <= S_FINAL;
						end else begin
							st_q    <= (req_type == REQ_CONNECT) ? ST_FULL : ST_OK;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (found) begin
						st_q    <= ST_OK;
						v_s1    <= 1'b0;
						state_q <= S_FINAL;
					end else if (scan_end) begin
						v_s1    <= 1'b0;
						state_q <= S_FINAL;
					end else begin
						v_s1 <= rd_en;
					end
				end
				S_FINAL: begin
					v_s1    <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/sst_checker.sv */
// ----------------------------------------------------------------------------
// sst_checker
// port level checks on result framing against the request handshake
// ----------------------------------------------------------------------------
`default_nettype none

`include "signal_subscription_table_core_macros.svh"

module sst_checker import sst_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic       dispatch,
	input wire logic [1:0] status,
	input wire logic       last
);

	// every result but the closing one is a dispatch with ok status
	`SST_ASSERT_NOW(a_mid_is_dispatch, strobe && !last, dispatch && status == ST_OK, "non-final result is not an ok dispatch")

	// closing result releases the request side, earlier results keep it busy
	`SST_ASSERT_NOW(a_last_frees, strobe && last, !busy && !dispatch, "closing result while busy or dispatching")

	`SST_ASSERT_NOW(a_mid_busy, strobe && !last, busy, "dispatch result while not busy")

	// an accepted request holds busy and gives no result in the next cycle
	`SST_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe, "accepted request did not go busy")

endmodule

bind signal_subscription_table_core sst_checker u_sst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.strobe   (strobe),
	.dispatch (dispatch),
	.status   (status),
	.last     (last)
);

`default_nettype wire
